// ===== rtl/core/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and codes for the double-ended queue core
// ----------------------------------------------------------------------------
package deq_pkg;

    // default number of words the queue holds
    localparam int DEQ_CAPACITY = 16;

    // request codes
    localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [2:0] FN_POP_FRONT  = 3'd2;
    localparam logic [2:0] FN_POP_BACK   = 3'd3;
    localparam logic [2:0] FN_PEEK_FRONT = 3'd4;
    localparam logic [2:0] FN_PEEK_BACK  = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift_right;  // push at front: every cell takes its left neighbor
        logic shift_left;   // pop at front: every cell takes its right neighbor
        logic load_tail;    // first empty cell captures the pushed word
        logic drop_tail;    // last occupied cell drops its word
    } deq_ctl_t;

    // one result item
    typedef struct packed {
        logic [1:0]        status;
        logic signed [31:0] read_value;
        logic              empty_flag;
        logic [4:0]        occupancy;
    } deq_rsp_t;

endpackage

// ===== rtl/core/deq_if.sv =====
// ----------------------------------------------------------------------------
// deq_if
// valid/ready channels for requests and results of the queue core
// ----------------------------------------------------------------------------
interface deq_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface deq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic               empty_flag;
    logic [4:0]         occupancy;

    modport source (output valid, output status, output read_value,
                    output empty_flag, output occupancy, input ready);
    modport sink   (input valid, input status, input read_value,
                    input empty_flag, input occupancy, output ready);
endinterface

// ===== rtl/core/deq_cell.sv =====
// ----------------------------------------------------------------------------
// deq_cell
// one slot of the queue: a word, an occupied flag and neighbor hand-off
// ----------------------------------------------------------------------------
module deq_cell
    import deq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  deq_ctl_t           ctl,
    input  logic signed [31:0] push_word,
    input  logic signed [31:0] left_data,
    input  logic               left_valid,
    input  logic signed [31:0] right_data,
    input  logic               right_valid,
    output logic signed [31:0] data,
    output logic               valid,
    output logic signed [31:0] tail_term
);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic               valid_reg;
    logic               valid_next;
    logic               is_tail;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctl.shift_right)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (ctl.shift_left)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (ctl.load_tail && !valid_reg && left_valid)
        begin
            data_next  = push_word;
            valid_next = 1'b1;
        end
        else if (ctl.drop_tail && valid_reg && !right_valid)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // last occupied cell
    assign is_tail   = valid_reg && !right_valid;
    assign tail_term = is_tail ? data_reg : 32'sd0;
    assign data      = data_reg;
    assign valid     = valid_reg;

endmodule

// ===== rtl/core/deq_chain.sv =====
// ----------------------------------------------------------------------------
// deq_chain
// row of queue cells, front at cell zero, plus front and back read-out
// ----------------------------------------------------------------------------
module deq_chain
    import deq_pkg::*;
#(
    parameter int CAPACITY = DEQ_CAPACITY
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  deq_ctl_t           ctl,
    input  logic signed [31:0] push_word,
    output logic signed [31:0] front_word,
    output logic signed [31:0] back_word
);

    logic signed [31:0] cell_data [CAPACITY];
    logic               cell_valid [CAPACITY];
    logic signed [31:0] cell_tail [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] l_data;
        logic               l_valid;
        logic signed [31:0] r_data;
        logic               r_valid;

        if (i == 0)
        begin : g_first
            assign l_data  = push_word;
            assign l_valid = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_data  = cell_data[i-1];
            assign l_valid = cell_valid[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign r_data  = 32'sd0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_data  = cell_data[i+1];
            assign r_valid = cell_valid[i+1];
        end

        deq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .push_word  (push_word),
            .left_data  (l_data),
            .left_valid (l_valid),
            .right_data (r_data),
            .right_valid(r_valid),
            .data       (cell_data[i]),
            .valid      (cell_valid[i]),
            .tail_term  (cell_tail[i])
        );
    end

    assign front_word = cell_data[0];

    // at most one cell flags itself as tail
    always_comb
    begin
        back_word = 32'sd0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            back_word = back_word | cell_tail[i];
        end
    end

endmodule

// ===== rtl/core/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core
// bounded double-ended queue of signed 32-bit words in a row of shift cells
// ----------------------------------------------------------------------------
// The queue keeps its words in a row of CAPACITY cells, front word in cell
// zero and the rest packed behind it. Each request on req (push front, push
// back, pop front, pop back, peek front, peek back) produces exactly one
// result on rsp with a status, the word read, an empty flag and the count
// held afterward. A pop or peek on an empty queue reports an empty error;
// a push into a full queue is dropped and reports a full error. Unused
// function codes leave the queue as it is and return ok with the current
// count. One request is accepted per clock: the cell row shifts or loads in
// the accept cycle and the result is registered, into the skid stage if the
// output stage still holds one. A two-entry result buffer lets a new request
// in while one result still waits; req.ready drops only when both entries
// are held. occupancy carries the low five bits of the count.
// ----------------------------------------------------------------------------
module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int CAPACITY = DEQ_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    deq_req_if.sink   req,
    deq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // occupancy count
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W+4:0]   cnt_wide;

    // result buffer: output stage plus skid stage
    deq_rsp_t           out_reg;
    deq_rsp_t           out_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    deq_rsp_t           skid_reg;
    deq_rsp_t           skid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;

    logic               req_xfer;
    logic               rsp_xfer;
    logic               is_full;
    logic               is_emp;
    deq_ctl_t           ctl;
    deq_ctl_t           ctl_gated;
    logic [1:0]         status;
    logic signed [31:0] rd_word;
    logic signed [31:0] front_word;
    logic signed [31:0] back_word;
    deq_rsp_t           result;

    assign req.ready = !skid_valid_reg;
    assign req_xfer  = req.valid && req.ready;
    assign rsp_xfer  = rsp.valid && rsp.ready;

    assign is_full = (cnt_reg == CNT_W'(CAPACITY));
    assign is_emp  = (cnt_reg == '0);

    // decode the request against the current count
    always_comb
    begin
        ctl      = '0;
        status   = ST_OK;
        rd_word  = 32'sd0;
        cnt_next = cnt_reg;
        case (req.func)
            FN_PUSH_FRONT, FN_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctl.shift_right = (req.func == FN_PUSH_FRONT);
                    ctl.load_tail   = (req.func == FN_PUSH_BACK);
                    cnt_next        = cnt_reg + CNT_W'(1);
                end
            end
            FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK:
            begin
                if (is_emp)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    if (req.func == FN_POP_FRONT || req.func == FN_PEEK_FRONT)
                    begin
                        rd_word = front_word;
                    end
                    else
                    begin
                        rd_word = back_word;
                    end
                    ctl.shift_left = (req.func == FN_POP_FRONT);
                    ctl.drop_tail  = (req.func == FN_POP_BACK);
                    if (req.func == FN_POP_FRONT || req.func == FN_POP_BACK)
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                // no operation
            end
        endcase
    end

    // cells move only on a request transfer
    assign ctl_gated = req_xfer ? ctl : '0;

    assign cnt_wide = {5'd0, cnt_next};

    assign result.status     = status;
    assign result.read_value = rd_word;
    assign result.empty_flag = (cnt_next == '0);
    assign result.occupancy  = cnt_wide[4:0];

    deq_chain #(
        .CAPACITY(CAPACITY)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_gated),
        .push_word (req.value),
        .front_word(front_word),
        .back_word (back_word)
    );

    // result buffer steering
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            // no request transfer possible while skid is held
            if (rsp_xfer)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (req_xfer)
        begin
            if (!out_valid_reg || rsp_xfer)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (rsp_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_xfer)
            begin
                cnt_reg <= cnt_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload stages, no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.read_value = out_reg.read_value;
    assign rsp.empty_flag = out_reg.empty_flag;
    assign rsp.occupancy  = out_reg.occupancy;

endmodule

// ===== rtl/core/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker
// port-level checks for the double-ended queue core
// ----------------------------------------------------------------------------
module deq_checker
    import deq_pkg::*;
#(
    parameter int CAPACITY = DEQ_CAPACITY
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [1:0]         rsp_status,
    input logic signed [31:0] rsp_read_value,
    input logic               rsp_empty_flag,
    input logic [4:0]         rsp_occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W+4:0] CAP_WIDE = (CNT_W + 5)'(CAPACITY);
    localparam logic [4:0] CAP_LOW = CAP_WIDE[4:0];

    // after every request transfer a result is valid in the following cycle
    a_req_answered: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("request transfer without a result");

    // a stalled result keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_read_value) && $stable(rsp_occupancy))
        else $error("stalled result changed");

    // an empty error leaves nothing held and reads zero
    a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_EMPTY |->
            rsp_empty_flag && rsp_occupancy == 5'd0 && rsp_read_value == 32'sd0)
        else $error("empty error with words held");

    // a full error reports a full queue and reads zero
    a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |->
            !rsp_empty_flag && rsp_occupancy == CAP_LOW && rsp_read_value == 32'sd0)
        else $error("full error on a queue that is not full");

    // empty flag agrees with the count
    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_empty_flag |-> rsp_occupancy == 5'd0)
        else $error("empty flag with nonzero occupancy");

endmodule

bind double_ended_queue_core deq_checker #(
    .CAPACITY(CAPACITY)
) u_deq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_read_value(rsp.read_value),
    .rsp_empty_flag(rsp.empty_flag),
    .rsp_occupancy (rsp.occupancy)
);
